FILE: src/ps2t_pkg.sv
// Shared types and constants of the PS/2 device byte transmitter.
`default_nettype none
package ps2t_pkg;

    localparam int TICK_W  = 12;
    localparam int RETRY_W = 7;

    // Engine phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POLL    = 3'd1;
    localparam logic [2:0] PH_HIGHRUN = 3'd2;
    localparam logic [2:0] PH_SEG_A   = 3'd3;
    localparam logic [2:0] PH_SEG_B   = 3'd4;
    localparam logic [2:0] PH_SEG_C   = 3'd5;
    localparam logic [2:0] PH_RELEASE = 3'd6;

    localparam logic [3:0] LAST_BIT     = 4'd10;
    localparam logic [3:0] POLL_SPACING = 4'd10;
    localparam logic [7:0] SETTLE_TICKS = 8'd8;
    localparam logic [7:0] PRE_TICKS    = 8'd6;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RETRY   = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_IDLE_HIGH   = 2'd1;
    localparam logic [1:0] REG_POLL_LIMIT  = 2'd2;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

    typedef struct packed {
        logic [7:0]  half_period_us;
        logic [9:0]  idle_high_us;
        logic [11:0] poll_limit;
        logic [5:0]  max_retries;
    } cfg_t;

    // One classified tick as held in the queue
    typedef struct packed {
        logic       is_req;
        logic [7:0] tx_byte;
        logic       parity;
        logic       host_line;
    } entry_t;

    // Queue to engine handshake
    typedef struct packed {
        logic   valid;
        entry_t data;
    } q_out_t;

endpackage
`default_nettype wire

FILE: src/ps2t_if.sv
// Channel interfaces for tick requests and result items.
`default_nettype none
interface ps2t_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] tx_byte;
    logic       host_line;

    modport source(output valid, req_type, tx_byte, host_line, input ready);
    modport sink(input valid, req_type, tx_byte, host_line, output ready);
endinterface

interface ps2t_out_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       dat_level;
    logic       drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;

    modport source(output valid, clk_level, dat_level, drive_enable, busy_res,
                   done_res, status, input ready);
    modport sink(input valid, clk_level, dat_level, drive_enable, busy_res,
                 done_res, status, output ready);
endinterface
`default_nettype wire

FILE: src/ps2t_cfg.sv
// APB register file holding the transmitter timing settings.
`default_nettype none
module ps2t_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ps2t_pkg::cfg_t    cfg
);

    ps2t_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_us <= 8'd50;
            cfg_reg.idle_high_us   <= 10'd100;
            cfg_reg.poll_limit     <= 12'd1000;
            cfg_reg.max_retries    <= 6'd20;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ps2t_pkg::REG_HALF_PERIOD: cfg_reg.half_period_us <= pwdata[7:0];
                ps2t_pkg::REG_IDLE_HIGH:   cfg_reg.idle_high_us   <= pwdata[9:0];
                ps2t_pkg::REG_POLL_LIMIT:  cfg_reg.poll_limit     <= pwdata[11:0];
                ps2t_pkg::REG_MAX_RETRIES: cfg_reg.max_retries    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ps2t_pkg::REG_HALF_PERIOD: prdata = {24'd0, cfg_reg.half_period_us};
            ps2t_pkg::REG_IDLE_HIGH:   prdata = {22'd0, cfg_reg.idle_high_us};
            ps2t_pkg::REG_POLL_LIMIT:  prdata = {20'd0, cfg_reg.poll_limit};
            ps2t_pkg::REG_MAX_RETRIES: prdata = {26'd0, cfg_reg.max_retries};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/ps2t_front.sv
// Front end: accept tick requests and classify them into queue entries.
`default_nettype none
module ps2t_front (
    ps2t_in_if.sink          ticks,
    input  wire logic        q_full,
    output logic             push,
    output ps2t_pkg::entry_t push_data
);

    assign ticks.ready = !q_full;
    assign push        = ticks.valid && !q_full;

    // Odd parity bit is the complement of this XOR; work it out once here
    assign push_data.is_req    = ticks.req_type;
    assign push_data.tx_byte   = ticks.tx_byte;
    assign push_data.parity    = ^ticks.tx_byte;
    assign push_data.host_line = ticks.host_line;

endmodule
`default_nettype wire

FILE: src/ps2t_queue.sv
// Short FIFO between the front end and the bit engine.
`default_nettype none
module ps2t_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  ps2t_pkg::entry_t      push_data,
    output logic                  full,
    input  wire logic             pop,
    output ps2t_pkg::q_out_t      q_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ps2t_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign q_out.valid = (count_reg != '0);
    assign q_out.data  = mem[rd_ptr_reg];
    assign do_pop      = pop && q_out.valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/ps2t_engine.sv
// Back end: step the frame state machine once per tick and register results.
`default_nettype none
module ps2t_engine (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  ps2t_pkg::cfg_t    cfg,
    input  ps2t_pkg::q_out_t  q_out,
    output logic              pop,
    ps2t_out_if.source        results
);

    logic [2:0]                  phase_reg, phase_next;
    logic [3:0]                  bit_reg, bit_next;
    logic [7:0]                  shift_reg, shift_next;
    logic                        parity_reg, parity_next;
    logic [ps2t_pkg::TICK_W-1:0] tick_reg, tick_next, tick_inc;
    logic [ps2t_pkg::RETRY_W-1:0] retry_reg, retry_next;

    logic       out_valid_reg;
    logic       clk_lvl_reg, dat_lvl_reg, drv_reg, busy_reg, done_reg;
    logic [1:0] status_reg;
    logic       clk_lvl, dat_lvl, drv, busy, done;
    logic [1:0] status;
    logic [7:0] len_a, len_c;

    ps2t_pkg::entry_t it;

    function automatic logic level_of(input logic [3:0] k, input logic [7:0] sb,
                                      input logic par);
        logic lvl;
        if (k == 4'd0)
            lvl = 1'b0;
        else if (k <= 4'd8)
            lvl = sb[3'(k - 4'd1)];
        else if (k == 4'd9)
            lvl = !par;
        else
            lvl = 1'b1;
        return lvl;
    endfunction

    assign it  = q_out.data;
    assign pop = q_out.valid && (!out_valid_reg || results.ready);

    assign tick_inc = tick_reg + 1'b1;
    assign len_a = (bit_reg == 4'd0) ? ps2t_pkg::PRE_TICKS :
                   (cfg.half_period_us > ps2t_pkg::SETTLE_TICKS) ?
                   (cfg.half_period_us - ps2t_pkg::SETTLE_TICKS) : 8'd1;
    assign len_c = (cfg.half_period_us != 8'd0) ? cfg.half_period_us : 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        parity_next = parity_reg;
        tick_next   = tick_reg;
        retry_next  = retry_reg;
        clk_lvl = 1'b0;
        dat_lvl = 1'b0;
        drv     = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        status  = ps2t_pkg::ST_OK;

        unique case (phase_reg)
            ps2t_pkg::PH_IDLE:
            begin
                if (it.is_req)
                begin
                    shift_next  = it.tx_byte;
                    parity_next = it.parity;
                    retry_next  = '0;
                    phase_next  = ps2t_pkg::PH_POLL;
                    tick_next   = '0;
                    bit_next    = '0;
                    busy        = 1'b1;
                end
            end
            ps2t_pkg::PH_POLL:
            begin
                busy = 1'b1;
                if (bit_reg == 4'd0)
                begin
                    if (it.host_line)
                    begin
                        if (retry_reg > {1'b0, cfg.max_retries})
                        begin
                            phase_next = ps2t_pkg::PH_IDLE;
                            busy   = 1'b0;
                            done   = 1'b1;
                            status = ps2t_pkg::ST_RETRY;
                        end
                        else
                        begin
                            retry_next = retry_reg + 1'b1;
                            phase_next = ps2t_pkg::PH_HIGHRUN;
                            tick_next  = '0;
                        end
                    end
                    else if (tick_reg >= cfg.poll_limit)
                    begin
                        phase_next = ps2t_pkg::PH_IDLE;
                        busy   = 1'b0;
                        done   = 1'b1;
                        status = ps2t_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        bit_next  = 4'd1;
                    end
                end
                else
                begin
                    bit_next = (bit_reg == ps2t_pkg::POLL_SPACING - 4'd1) ? 4'd0
                                                                          : bit_reg + 4'd1;
                end
            end
            ps2t_pkg::PH_HIGHRUN:
            begin
                busy = 1'b1;
                if (it.host_line)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {2'b00, cfg.idle_high_us})
                    begin
                        phase_next = ps2t_pkg::PH_SEG_A;
                        bit_next   = '0;
                        tick_next  = '0;
                    end
                end
                else
                begin
                    phase_next = ps2t_pkg::PH_POLL;
                    tick_next  = '0;
                    bit_next   = '0;
                end
            end
            ps2t_pkg::PH_SEG_A:
            begin
                busy    = 1'b1;
                drv     = 1'b1;
                clk_lvl = 1'b1;
                dat_lvl = (bit_reg == 4'd0) ? 1'b1
                                            : level_of(bit_reg - 4'd1, shift_reg, parity_reg);
                tick_next = tick_inc;
                if (tick_inc >= {4'd0, len_a})
                begin
                    phase_next = ps2t_pkg::PH_SEG_B;
                    tick_next  = '0;
                end
            end
            ps2t_pkg::PH_SEG_B:
            begin
                busy = 1'b1;
                if (tick_reg == '0 && !it.host_line)
                begin
                    phase_next = ps2t_pkg::PH_POLL;
                    tick_next  = '0;
                    bit_next   = '0;
                end
                else
                begin
                    drv       = 1'b1;
                    clk_lvl   = 1'b1;
                    dat_lvl   = level_of(bit_reg, shift_reg, parity_reg);
                    tick_next = tick_inc;
                    if (tick_inc >= {4'd0, ps2t_pkg::SETTLE_TICKS})
                    begin
                        phase_next = ps2t_pkg::PH_SEG_C;
                        tick_next  = '0;
                    end
                end
            end
            ps2t_pkg::PH_SEG_C:
            begin
                busy      = 1'b1;
                drv       = 1'b1;
                dat_lvl   = level_of(bit_reg, shift_reg, parity_reg);
                tick_next = tick_inc;
                if (tick_inc >= {4'd0, len_c})
                begin
                    tick_next = '0;
                    if (bit_reg >= ps2t_pkg::LAST_BIT)
                    begin
                        phase_next = ps2t_pkg::PH_RELEASE;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 4'd1;
                        phase_next = ps2t_pkg::PH_SEG_A;
                    end
                end
            end
            ps2t_pkg::PH_RELEASE:
            begin
                busy = 1'b1;
                if (it.host_line)
                begin
                    phase_next = ps2t_pkg::PH_IDLE;
                    busy   = 1'b0;
                    done   = 1'b1;
                    status = ps2t_pkg::ST_OK;
                end
            end
            default:
            begin
                phase_next = ps2t_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ps2t_pkg::PH_IDLE;
            bit_reg       <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b0;
            tick_reg      <= '0;
            retry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg  <= phase_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                parity_reg <= parity_next;
                tick_reg   <= tick_next;
                retry_reg  <= retry_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            clk_lvl_reg <= clk_lvl;
            dat_lvl_reg <= dat_lvl;
            drv_reg     <= drv;
            busy_reg    <= busy;
            done_reg    <= done;
            status_reg  <= status;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.clk_level    = clk_lvl_reg;
    assign results.dat_level    = dat_lvl_reg;
    assign results.drive_enable = drv_reg;
    assign results.busy_res     = busy_reg;
    assign results.done_res     = done_reg;
    assign results.status       = status_reg;

endmodule
`default_nettype wire

FILE: src/ps2_device_byte_transmitter.sv
// Top level of the PS/2 device byte transmitter: front end, queue, engine, registers.
// A request taken into the queue is stepped by the engine once the output register is free,
// and its result is registered there. One tick per cycle while the result channel takes results.
// The queue holds QUEUE_DEPTH requests and the output register one more while the
// result channel stalls; the input then stalls until a result is taken.
// Reset (rst_n low, asynchronous): engine idle, queue and output empty, registers to defaults.
`default_nettype none
module ps2_device_byte_transmitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ps2t_in_if.sink          ticks,
    ps2t_out_if.source       results,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ps2t_pkg::cfg_t   cfg;
    ps2t_pkg::entry_t push_data;
    ps2t_pkg::q_out_t q_out;
    logic             push, q_full, pop;

    // Timing registers; the user must write them only while no send is in flight (not enforced here)
    ps2t_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a request whenever the queue has room and tag it with its parity
    ps2t_front u_front (
        .ticks     (ticks),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple acceptance from result backpressure
    ps2t_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_out     (q_out)
    );

    // Advance the frame one tick per popped request; hold the result until taken
    ps2t_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_out   (q_out),
        .pop     (pop),
        .results (results)
    );

    // A send never reports busy and done on the same tick
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.busy_res && results.done_res))
        else $error("busy and done asserted together");

    // Released lines carry no driven level
    a_release_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.drive_enable) |->
            (!results.clk_level && !results.dat_level))
        else $error("line level set while released");

    // Status is only meaningful on a done tick
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.done_res) |-> (results.status == ps2t_pkg::ST_OK))
        else $error("status set without done");

    // Driving the bus implies a send in progress
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.drive_enable) |-> results.busy_res)
        else $error("lines driven outside a send");

endmodule
`default_nettype wire

FILE: tb/ps2t_checker.sv
// Checker for the PS/2 byte transmitter: predicts each tick's line state and compares results.
module ps2t_checker (
    input  logic        clk,
    input  logic        rst_n,
    ps2t_in_if          ticks,
    ps2t_out_if         results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        wrap_up,
    output int unsigned fail_count
);

    typedef struct packed {
        logic       clk_level;
        logic       dat_level;
        logic       drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } line_state_t;

    ps2t_pkg::cfg_t cfg;
    logic [2:0]     phase;
    int unsigned    bit_pos;
    logic [7:0]     frame_byte;
    logic           frame_parity;
    int unsigned    tick_cnt;
    int unsigned    retries;
    bit             wrapped;
    line_state_t    expected_lines[$];

    // Level of frame bit k: start, eight data bits LSB first, odd parity, stop.
    function automatic logic frame_bit(input int unsigned k);
        if (k == 0) return 1'b0;
        if (k <= 8) return frame_byte[k - 1];
        if (k == 9) return ~frame_parity;
        return 1'b1;
    endfunction

    function automatic void restart_polling();
        phase    = ps2t_pkg::PH_POLL;
        tick_cnt = 0;
        bit_pos  = 0;
    endfunction

    function automatic line_state_t end_send(input logic [1:0] code);
        line_state_t r;
        r          = '0;
        r.done_res = 1'b1;
        r.status   = code;
        phase      = ps2t_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic line_state_t step_transmitter(input logic req,
                                                     input logic [7:0] data_byte,
                                                     input logic host);
        line_state_t r;
        int unsigned seg_len;
        r = '0;
        case (phase)
            ps2t_pkg::PH_IDLE: begin
                if (req) begin
                    frame_byte   = data_byte;
                    frame_parity = ^data_byte;
                    retries      = 0;
                    restart_polling();
                    r.busy_res = 1'b1;
                end
            end
            ps2t_pkg::PH_POLL: begin
                r.busy_res = 1'b1;
                if (bit_pos == 0) begin
                    if (host) begin
                        if (retries > 32'(cfg.max_retries)) begin
                            r = end_send(ps2t_pkg::ST_RETRY);
                        end
                        else begin
                            retries++;
                            phase    = ps2t_pkg::PH_HIGHRUN;
                            tick_cnt = 0;
                        end
                    end
                    else if (tick_cnt >= 32'(cfg.poll_limit)) begin
                        r = end_send(ps2t_pkg::ST_TIMEOUT);
                    end
                    else begin
                        tick_cnt++;
                        bit_pos = 1;
                    end
                end
                else begin
                    bit_pos = (bit_pos + 1 >= 32'(ps2t_pkg::POLL_SPACING)) ? 0 : bit_pos + 1;
                end
            end
            ps2t_pkg::PH_HIGHRUN: begin
                r.busy_res = 1'b1;
                if (host) begin
                    tick_cnt++;
                    if (tick_cnt >= 32'(cfg.idle_high_us)) begin
                        phase    = ps2t_pkg::PH_SEG_A;
                        bit_pos  = 0;
                        tick_cnt = 0;
                    end
                end
                else begin
                    restart_polling();
                end
            end
            ps2t_pkg::PH_SEG_A: begin
                r.busy_res     = 1'b1;
                r.drive_enable = 1'b1;
                r.clk_level    = 1'b1;
                r.dat_level    = (bit_pos == 0) ? 1'b1 : frame_bit(bit_pos - 1);
                tick_cnt++;
                if (bit_pos == 0)
                    seg_len = 32'(ps2t_pkg::PRE_TICKS);
                else if (cfg.half_period_us > ps2t_pkg::SETTLE_TICKS)
                    seg_len = 32'(cfg.half_period_us - ps2t_pkg::SETTLE_TICKS);
                else
                    seg_len = 1;
                if (tick_cnt >= seg_len) begin
                    phase    = ps2t_pkg::PH_SEG_B;
                    tick_cnt = 0;
                end
            end
            ps2t_pkg::PH_SEG_B: begin
                r.busy_res = 1'b1;
                // host pulled the clock low at the start of B: abort the frame
                if (tick_cnt == 0 && !host) begin
                    restart_polling();
                end
                else begin
                    r.drive_enable = 1'b1;
                    r.clk_level    = 1'b1;
                    r.dat_level    = frame_bit(bit_pos);
                    tick_cnt++;
                    if (tick_cnt >= 32'(ps2t_pkg::SETTLE_TICKS)) begin
                        phase    = ps2t_pkg::PH_SEG_C;
                        tick_cnt = 0;
                    end
                end
            end
            ps2t_pkg::PH_SEG_C: begin
                r.busy_res     = 1'b1;
                r.drive_enable = 1'b1;
                r.dat_level    = frame_bit(bit_pos);
                tick_cnt++;
                seg_len = (cfg.half_period_us == 0) ? 1 : 32'(cfg.half_period_us);
                if (tick_cnt >= seg_len) begin
                    tick_cnt = 0;
                    if (bit_pos >= 32'(ps2t_pkg::LAST_BIT)) begin
                        phase = ps2t_pkg::PH_RELEASE;
                    end
                    else begin
                        bit_pos++;
                        phase = ps2t_pkg::PH_SEG_A;
                    end
                end
            end
            ps2t_pkg::PH_RELEASE: begin
                r.busy_res = 1'b1;
                if (host)
                    r = end_send(ps2t_pkg::ST_OK);
            end
            default: begin
                phase = ps2t_pkg::PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        $error("%s", msg);
    endfunction

    function automatic void compare_line(input string field, input logic [1:0] want,
                                         input logic [1:0] got);
        if (want !== got)
            report_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
    endfunction

    always @(posedge clk or negedge rst_n) begin
        line_state_t want;
        if (!rst_n) begin
            cfg.half_period_us = 8'd50;
            cfg.idle_high_us   = 10'd100;
            cfg.poll_limit     = 12'd1000;
            cfg.max_retries    = 6'd20;
            phase        = ps2t_pkg::PH_IDLE;
            bit_pos      = 0;
            frame_byte   = '0;
            frame_parity = 1'b0;
            tick_cnt     = 0;
            retries      = 0;
            fail_count   = 0;
            wrapped      = 1'b0;
            expected_lines.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    ps2t_pkg::REG_HALF_PERIOD: cfg.half_period_us = pwdata[7:0];
                    ps2t_pkg::REG_IDLE_HIGH:   cfg.idle_high_us   = pwdata[9:0];
                    ps2t_pkg::REG_POLL_LIMIT:  cfg.poll_limit     = pwdata[11:0];
                    ps2t_pkg::REG_MAX_RETRIES: cfg.max_retries    = pwdata[5:0];
                    default: ;
                endcase
            end
            if (ticks.valid && ticks.ready)
                expected_lines.push_back(step_transmitter(ticks.req_type, ticks.tx_byte,
                                                          ticks.host_line));
            if (results.valid && results.ready) begin
                if (expected_lines.size() == 0) begin
                    report_failure("result arrived with no request pending");
                end
                else begin
                    want = expected_lines.pop_front();
                    compare_line("clk_level", {1'b0, want.clk_level},
                                 {1'b0, results.clk_level});
                    compare_line("dat_level", {1'b0, want.dat_level},
                                 {1'b0, results.dat_level});
                    compare_line("drive_enable", {1'b0, want.drive_enable},
                                 {1'b0, results.drive_enable});
                    compare_line("busy_res", {1'b0, want.busy_res},
                                 {1'b0, results.busy_res});
                    compare_line("done_res", {1'b0, want.done_res},
                                 {1'b0, results.done_res});
                    compare_line("status", want.status, results.status);
                end
            end
            if (wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_lines.size() != 0) begin
                    report_failure($sformatf("%0d results never arrived",
                                             expected_lines.size()));
                    fail_count += expected_lines.size() - 1;
                end
            end
        end
    end

endmodule

FILE: tb/ps2_device_byte_transmitter_test.sv
// Testbench top for the PS/2 byte transmitter: clock, reset, register setup, tick traffic, verdict.
module ps2_device_byte_transmitter_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 80;   // cycles the result side holds off under pressure
    localparam int SETTLE_WAIT = 4;    // result passes the queue and output register; allow margin

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        wrap_up;
    int unsigned fail_count;

    int unsigned requests_sent = 0;
    int unsigned results_taken = 0;
    int unsigned hold_asks     = 0;
    int unsigned holds_served  = 0;
    int unsigned cycles        = 0;
    bit          calm          = 1'b0; // no gaps on either side while set
    int unsigned cur_half      = 50;
    int unsigned cur_idle      = 100;

    ps2t_in_if  tick_ch();
    ps2t_out_if result_ch();

    ps2_device_byte_transmitter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ticks   (tick_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ps2t_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .ticks      (tick_ch),
        .results    (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .wrap_up    (wrap_up),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap length for either side: mostly none, often short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Count accepted results.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_taken <= results_taken + 1;
        end
    end

    // Result side: stall at random, and hold off for a long stretch when asked.
    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_asks != holds_served)
            begin
                holds_served++;
                stall = LONG_HOLD;
            end
            else
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog: give up well past the slowest legal run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Offer one tick request and hold it until accepted. Keep valid high on return so a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_tick(input logic req, input logic [7:0] data_byte, input logic host);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.req_type  <= req;
        tick_ch.tx_byte   <= data_byte;
        tick_ch.host_line <= host;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every request has its result; always advance past a clock edge.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_taken != requests_sent);
    endtask

    // Two-phase register write: setup, then access; the register takes it at the access edge.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Write new timing once no request is in flight; a send in progress carries on under it.
    task automatic apply_settings(input int unsigned half, input int unsigned idle_run,
                                  input int unsigned polls, input int unsigned retry_max);
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        write_register(ps2t_pkg::REG_HALF_PERIOD, 32'(half));
        write_register(ps2t_pkg::REG_IDLE_HIGH, 32'(idle_run));
        write_register(ps2t_pkg::REG_POLL_LIMIT, 32'(polls));
        write_register(ps2t_pkg::REG_MAX_RETRIES, 32'(retry_max));
        cur_half = half;
        cur_idle = idle_run;
    endtask

    // Random junk: stray requests, host line flipping at random.
    task automatic send_noise(inout int left);
        int n;
        n = $urandom_range(5, 40);
        while (n > 0 && left > 0)
        begin
            send_tick($urandom_range(0, 4) == 0, 8'($urandom), 1'($urandom_range(0, 1)));
            n--;
            left--;
        end
    endtask

    // One well-formed send: request, optional low polls, a clean high run, then a frame
    // whose host line is random except at the sampled start of each B segment, where it
    // is held high (rarely low, to force an abort). Optionally keep the line low past the
    // stop bit so the release phase has to wait.
    task automatic send_frame_attempt(inout int left);
        int polls;
        int tail;
        int extra;
        int idle_eff;
        int a_len;
        int c_len;
        int bit_len;
        int f0;
        int rel;
        int last;
        int idx;
        int t;
        logic host;
        polls    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        tail     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        extra    = $urandom_range(0, 4);
        idle_eff = (cur_idle == 0) ? 1 : cur_idle;
        a_len    = (cur_half > 8) ? cur_half - 8 : 1;
        c_len    = (cur_half == 0) ? 1 : cur_half;
        bit_len  = a_len + 8 + c_len;
        f0       = 2 + idle_eff + 10 * polls;
        rel      = f0 + 6 + 8 + c_len + 10 * bit_len;
        last     = rel + tail + extra;
        for (idx = 0; idx <= last && left > 0; idx++)
        begin
            t = idx - f0;
            if (idx == 0)
                host = 1'($urandom_range(0, 1));
            else if (idx <= 10 * polls)
                host = ((idx - 1) % 10 == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            else if (idx < f0)
                host = 1'b1;
            else if (idx < rel)
            begin
                if (t == 6 || (t >= 14 + c_len && (t - 14 - c_len) % bit_len == a_len))
                    host = ($urandom_range(0, 39) != 0);
                else
                    host = 1'($urandom_range(0, 1));
            end
            else if (idx < rel + tail)
                host = 1'b0;
            else
                host = 1'b1;
            send_tick(idx == 0 || $urandom_range(0, 29) == 0, 8'($urandom), host);
            left--;
        end
    endtask

    task automatic run_random(input int budget);
        int left;
        left = budget;
        while (left > 0)
        begin
            // Leave some stretches with no gaps at all on either side.
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                send_noise(left);
            else
                send_frame_attempt(left);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int left;
        // Hold every input at a known level and keep reset low, then release it.
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        wrap_up           <= 1'b0;
        tick_ch.valid     <= 1'b0;
        tick_ch.req_type  <= 1'b0;
        tick_ch.tx_byte   <= 8'h00;
        tick_ch.host_line <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tightest limits: half period 9 (one-tick A segment), one-tick high run, one poll, no retries.
        apply_settings(9, 1, 1, 0);

        // Directed: quiet ticks, then a send that times out on a line held low.
        send_tick(1'b0, 8'h00, 1'b0);
        send_tick(1'b0, 8'hFF, 1'b1);
        send_tick(1'b1, 8'hFF, 1'b0);   // load the byte, start polling next tick
        send_tick(1'b1, 8'h00, 1'b0);   // request while busy is ignored; first low sample
        repeat (9) send_tick(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
        send_tick(1'b0, 8'h00, 1'b0);   // second low sample reaches the poll limit
        // Directed: abort at the start bit, then the retry budget runs out.
        send_tick(1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 8'h00, 1'b1);   // high sample: first pass of the bus check
        send_tick(1'b0, 8'h00, 1'b1);   // a single high tick completes the run
        repeat (6) send_tick(1'b0, 8'h5A, 1'b1);
        send_tick(1'b0, 8'h00, 1'b0);   // low at the first B tick: release and poll again
        send_tick(1'b0, 8'h00, 1'b1);   // no restarts left: retry error
        run_random(60);

        // Short frames, a few polls, the largest retry budget.
        apply_settings(12, 5, 3, 63);
        run_random(80);

        // Every register at its top value: a long send, cut short by the item budget.
        apply_settings(255, 1023, 4095, 63);
        run_random(40);

        // Degenerate limits: zero half period, zero high run, zero poll limit.
        apply_settings(0, 0, 0, 1);
        run_random(80);

        // Moderate settings with back-pressure on both sides.
        apply_settings(20, 3, 2, 5);
        run_random(40);
        // Hold the result side off while requests keep coming: fill the queue, stall input.
        calm = 1'b1;
        hold_asks++;
        left = 80;
        send_frame_attempt(left);
        calm = 1'b0;
        // Pause the request side until every result is in, then resume.
        wait_drained();
        run_random(60);

        // Wind down: collect everything outstanding, then let the pipeline settle.
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
